[design/tslf_pkg.sv]
// shared types and constants of the text stream line filter
`default_nettype none

package tslf_pkg;

    // configuration register indexes
    localparam int unsigned CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_SQUEEZE_BLANK    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_NUMBER_ALL       = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER_I = 8'h49;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_OFFSET = 8'h40;

    typedef struct packed {
        logic squeeze_blank;
        logic number_nonblank;
        logic number_all;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_tslf_cfg;

    // escape prefix put before the final byte
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_CARET,
        PFX_META
    } t_pfx;

    // one classified item, as handed from front to back
    typedef struct packed {
        logic       has_num;
        logic       dollar;
        t_pfx       pfx;
        logic [7:0] ch;
    } t_tslf_desc;

endpackage

`default_nettype wire

[design/text_stream_line_filter.sv]
// top level of the text stream line filter
`default_nettype none

// Text line filter in the style of cat -benstv, one text byte per input item.
// Each accepted byte yields zero to NUMBER_DIGITS+5 output bytes, each carried
// as one output item with last set on the final byte of the input item. The
// front classifier takes one input item per clock while the queue has room:
// it tracks line start, the squeeze state and the BCD line count, and decides
// on numbering, the '$' marker and the caret or M-^ escape. Classified items
// wait in a four-entry queue; the back expander sends one output byte per
// clock while the receiver pops. A byte that expands to a single output byte
// therefore sustains one item per cycle; a longer expansion holds the
// expander until its last byte is sent, and the input side stalls (full)
// only once the queue has filled behind it. A squeezed blank line produces no
// output and never enters the queue. The first output byte of an item goes
// through the queue and the output register before it shows. Configuration is
// written through a plain write port and is meant to change only while the
// block is idle. The line count saturates at all nines; file_start clears the
// count and line state before its own byte is handled.
module text_stream_line_filter import tslf_pkg::*; #(
    parameter int unsigned NUMBER_DIGITS = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic              i_cfg_wdata,
    // input item side
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_file_start,
    // output item side
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             o_out_byte,
    output logic                   o_last
);
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned BW     = 4 * NUMBER_DIGITS;
    localparam int unsigned QW     = $bits(t_tslf_desc) + BW;

    t_tslf_cfg     r_cfg;
    logic          accept;
    logic          q_push, q_pop, q_full, q_empty;
    t_tslf_desc    f_desc, b_desc;
    logic [BW-1:0] f_bcd, b_bcd;
    logic [QW-1:0] q_rdata;

    // configuration registers, one bit each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_wdata;
                CFG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_wdata;
                CFG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_wdata;
                CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_wdata;
                CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_wdata;
                CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input item taken whenever the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    tslf_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .o_push       (q_push),
        .o_desc       (f_desc),
        .o_bcd        (f_bcd)
    );

    // classified items between front and back
    tslf_fifo #(
        .WIDTH(QW),
        .DEPTH(QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_desc, f_bcd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign b_desc = t_tslf_desc'(q_rdata[QW-1:BW]);
    assign b_bcd  = q_rdata[BW-1:0];

    tslf_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_desc     (b_desc),
        .i_bcd      (b_bcd),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

[design/tslf_fifo.sv]
// small register queue between the classifier and the expander
`default_nettype none

module tslf_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_data;
                r_wptr        <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/tslf_front.sv]
// classifier: line state, squeeze, line count and escape decision per item
`default_nettype none

module tslf_front import tslf_pkg::*; #(
    parameter int unsigned NUMBER_DIGITS = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_tslf_cfg                  i_cfg,
    input  wire logic                       i_accept,
    input  wire logic [7:0]                 i_in_byte,
    input  wire logic                       i_file_start,
    output logic                            o_push,
    output t_tslf_desc                      o_desc,
    output logic [4*NUMBER_DIGITS-1:0]      o_bcd
);
    localparam int unsigned BW = 4 * NUMBER_DIGITS;

    logic [BW-1:0] r_line_bcd;
    logic          r_at_start;
    logic          r_blank;

    logic [BW-1:0] eff_bcd, bcd_next;
    logic          eff_start, eff_blank, nl, drop, num;
    t_tslf_desc    desc;

    // bcd increment, holds at all nines
    function automatic logic [BW-1:0] count_up(input logic [BW-1:0] v);
        logic [BW-1:0] r;
        logic          carry;
        logic [3:0]    dig;
        r     = '0;
        carry = 1'b1;
        for (int d = 0; d < NUMBER_DIGITS; d++) begin
            dig = v[4*d +: 4];
            if (carry) begin
                if (dig >= 4'd9) begin
                    dig = 4'd0;
                end else begin
                    dig   = dig + 4'd1;
                    carry = 1'b0;
                end
            end
            r[4*d +: 4] = dig;
        end
        return carry ? v : r;
    endfunction

    always_comb begin
        eff_bcd   = i_file_start ? '0 : r_line_bcd;
        eff_start = i_file_start | r_at_start;
        eff_blank = !i_file_start & r_blank;
        nl        = (i_in_byte == CH_NL);
        drop      = i_cfg.squeeze_blank && nl && eff_start && eff_blank;
        num       = !drop && eff_start &&
                    (i_cfg.number_nonblank ? !nl : i_cfg.number_all);
        bcd_next  = num ? count_up(eff_bcd) : eff_bcd;

        desc.has_num = num;
        desc.dollar  = i_cfg.show_ends && nl;
        desc.pfx     = PFX_NONE;
        desc.ch      = i_in_byte;
        if (i_cfg.show_tabs && i_in_byte == CH_TAB) begin
            desc.pfx = PFX_CARET;
            desc.ch  = CH_UPPER_I;
        end else if (i_cfg.show_nonprinting) begin
            if (i_in_byte[7:5] == 3'b100) begin
                desc.pfx = PFX_META;
                desc.ch  = i_in_byte - CH_OFFSET;
            end else if ((i_in_byte[7:5] == 3'b000 && !nl && i_in_byte != CH_TAB)
                         || i_in_byte == CH_DEL) begin
                desc.pfx = PFX_CARET;
                desc.ch  = {1'b0, i_in_byte[6:0] + CH_OFFSET[6:0]};
            end
        end
    end

    assign o_push = i_accept && !drop;
    assign o_desc = desc;
    assign o_bcd  = bcd_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bcd <= '0;
            r_at_start <= 1'b1;
            r_blank    <= 1'b0;
        end else if (i_accept && !drop) begin
            r_line_bcd <= bcd_next;
            r_at_start <= nl;
            r_blank    <= i_cfg.squeeze_blank ? (nl && eff_start) : eff_blank;
        end
    end

endmodule

`default_nettype wire

[design/tslf_back.sv]
// expander: turns one queued item into its output bytes, one per cycle while the receiver pops
`default_nettype none

module tslf_back import tslf_pkg::*; #(
    parameter int unsigned NUMBER_DIGITS = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_empty,
    input  wire t_tslf_desc                 i_desc,
    input  wire logic [4*NUMBER_DIGITS-1:0] i_bcd,
    output logic                            o_q_pop,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last
);
    localparam int unsigned IW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    typedef enum logic [2:0] {
        ST_DIGIT,
        ST_TAB,
        ST_DOLLAR,
        ST_META,
        ST_DASH,
        ST_CARET,
        ST_FINAL
    } t_step;

    t_step         r_step;
    logic          r_mid;
    logic [IW-1:0] r_idx;
    logic          r_lead;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;

    t_step         cur_step, nxt_step;
    logic [IW-1:0] cur_idx;
    logic          lead_in, lead_now, is_final, advance;
    logic [3:0]    dig;
    logic [7:0]    byte_out;

    function automatic t_step after_dollar(input t_tslf_desc d);
        t_step s;
        unique case (d.pfx)
            PFX_META:  s = ST_META;
            PFX_CARET: s = ST_CARET;
            default:   s = ST_FINAL;
        endcase
        return s;
    endfunction

    function automatic t_step after_tab(input t_tslf_desc d);
        return d.dollar ? ST_DOLLAR : after_dollar(d);
    endfunction

    always_comb begin
        cur_step = r_mid ? r_step : (i_desc.has_num ? ST_DIGIT : after_tab(i_desc));
        cur_idx  = r_mid ? r_idx : IW'(NUMBER_DIGITS - 1);
        lead_in  = r_mid ? r_lead : 1'b1;
        dig      = i_bcd[4*cur_idx +: 4];
        lead_now = lead_in && (dig == 4'd0) && (cur_idx != '0);
        is_final = 1'b0;
        byte_out = i_desc.ch;
        nxt_step = ST_FINAL;
        unique case (cur_step)
            ST_DIGIT: begin
                byte_out = lead_now ? CH_SPACE : (CH_ZERO | {4'd0, dig});
                nxt_step = (cur_idx == '0) ? ST_TAB : ST_DIGIT;
            end
            ST_TAB: begin
                byte_out = CH_TAB;
                nxt_step = after_tab(i_desc);
            end
            ST_DOLLAR: begin
                byte_out = CH_DOLLAR;
                nxt_step = after_dollar(i_desc);
            end
            ST_META: begin
                byte_out = CH_UPPER_M;
                nxt_step = ST_DASH;
            end
            ST_DASH: begin
                byte_out = CH_DASH;
                nxt_step = ST_CARET;
            end
            ST_CARET: begin
                byte_out = CH_CARET;
                nxt_step = ST_FINAL;
            end
            default: begin
                byte_out = i_desc.ch;
                is_final = 1'b1;
            end
        endcase
        advance = !i_q_empty && (!r_ovalid || i_pop);
    end

    assign o_q_pop    = advance && is_final;
    assign o_empty    = !r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= 1'b0;
            r_ovalid <= 1'b0;
            r_step   <= ST_FINAL;
        end else begin
            if (advance) begin
                r_ovalid <= 1'b1;
                r_obyte  <= byte_out;
                r_olast  <= is_final;
                r_mid    <= !is_final;
                r_step   <= nxt_step;
                r_idx    <= (cur_step == ST_DIGIT) ? cur_idx - IW'(1) : cur_idx;
                r_lead   <= lead_now;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[design/tslf_checker.sv]
// port-level checks of the text stream line filter and their bind
`default_nettype none

module tslf_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [7:0]        o_out_byte,
    input wire logic              o_last
);

    // reset leaves nothing to read
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // reset leaves the queue with room
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    // an item stalled on the output holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("output item changed while stalled");

    // the bytes of one expansion follow without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> !empty)
        else $error("gap inside one expansion");

endmodule

bind text_stream_line_filter tslf_checker u_tslf_checker (.*);

`default_nettype wire

[sim/tslf_expansion_checker.sv]
// checker that predicts and compares the output items of the text stream line filter
`timescale 1ns / 100ps

module tslf_expansion_checker import tslf_pkg::*; #(
    parameter int unsigned NUMBER_DIGITS = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic              i_cfg_wdata,
    input  wire logic              push,
    input  wire logic              full,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_file_start,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire logic [7:0]        o_out_byte,
    input  wire logic              o_last,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam logic [7:0] CTRL_END       = 8'h20;
    localparam logic [7:0] HIGH_CTRL_LOW  = 8'h80;
    localparam logic [7:0] HIGH_CTRL_END  = 8'hA0;
    localparam int         MAX_EXPANSION  = NUMBER_DIGITS + 5;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_item;

    t_out_item                  expected_bytes_q [$];
    t_out_item                  oldest;
    t_tslf_cfg                  opts;
    logic [4*NUMBER_DIGITS-1:0] line_bcd;
    logic                       line_start;
    logic                       blank_seen;
    int                         fail_count = 0;

    assign o_fail_count = fail_count;

    // works out the output bytes of one accepted text byte
    task automatic expand_text_byte(input logic [7:0] raw, input logic first);
        logic [7:0]                 ch;
        logic [7:0]                 outs [MAX_EXPANSION];
        logic [4*NUMBER_DIGITS-1:0] next_bcd;
        logic                       nl;
        logic                       dropped;
        logic                       carry;
        logic                       lead;
        logic [3:0]                 dig;
        int                         n;
        ch      = raw;
        nl      = (raw == CH_NL);
        dropped = 1'b0;
        n       = 0;
        if (first) begin
            line_bcd   = '0;
            line_start = 1'b1;
            blank_seen = 1'b0;
        end
        if (opts.squeeze_blank) begin
            if (nl && line_start) begin
                if (blank_seen)
                    dropped = 1'b1;
                blank_seen = 1'b1;
            end else begin
                blank_seen = 1'b0;
            end
        end
        if (!dropped) begin
            if (line_start && (opts.number_nonblank ? !nl : opts.number_all)) begin
                // bcd increment, held at all nines
                next_bcd = line_bcd;
                carry    = 1'b1;
                for (int d = 0; d < NUMBER_DIGITS; d++) begin
                    if (carry) begin
                        if (next_bcd[4*d +: 4] >= 4'd9) begin
                            next_bcd[4*d +: 4] = 4'd0;
                        end else begin
                            next_bcd[4*d +: 4] = next_bcd[4*d +: 4] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
                if (!carry)
                    line_bcd = next_bcd;
                lead = 1'b1;
                for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
                    dig = line_bcd[4*d +: 4];
                    if (dig != 4'd0 || d == 0)
                        lead = 1'b0;
                    outs[n] = lead ? CH_SPACE : (CH_ZERO + dig);
                    n++;
                end
                outs[n] = CH_TAB;
                n++;
            end
            line_start = nl;
            if (opts.show_ends && nl) begin
                outs[n] = CH_DOLLAR;
                n++;
            end
            if (opts.show_tabs && ch == CH_TAB) begin
                outs[n] = CH_CARET;
                n++;
                ch = CH_TAB + CH_OFFSET;
            end
            if (opts.show_nonprinting) begin
                if (ch >= HIGH_CTRL_LOW && ch < HIGH_CTRL_END) begin
                    outs[n] = CH_UPPER_M;
                    outs[n+1] = CH_DASH;
                    outs[n+2] = CH_CARET;
                    n = n + 3;
                    ch = ch - CH_OFFSET;
                end else if ((ch < CTRL_END && ch != CH_NL && ch != CH_TAB) || ch == CH_DEL) begin
                    outs[n] = CH_CARET;
                    n++;
                    ch = (ch + CH_OFFSET) & 8'h7F;
                end
            end
            outs[n] = ch;
            n++;
            for (int k = 0; k < n; k++)
                expected_bytes_q.push_back('{ch: outs[k], last: (k == n - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            opts       = '0;
            line_bcd   = '0;
            line_start = 1'b1;
            blank_seen = 1'b0;
            expected_bytes_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SQUEEZE_BLANK:    opts.squeeze_blank    = i_cfg_wdata;
                    CFG_NUMBER_NONBLANK:  opts.number_nonblank  = i_cfg_wdata;
                    CFG_NUMBER_ALL:       opts.number_all       = i_cfg_wdata;
                    CFG_SHOW_ENDS:        opts.show_ends        = i_cfg_wdata;
                    CFG_SHOW_TABS:        opts.show_tabs        = i_cfg_wdata;
                    CFG_SHOW_NONPRINTING: opts.show_nonprinting = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (push && !full)
                expand_text_byte(i_in_byte, i_file_start);
            if (pop && !empty) begin
                if (expected_bytes_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected output item: byte %02h last %0b",
                                 o_out_byte, o_last);
                    fail_count++;
                end else begin
                    oldest = expected_bytes_q.pop_front();
                    if (oldest.ch !== o_out_byte || oldest.last !== o_last) begin
                        if (fail_count < 10)
                            $display("output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                     oldest.ch, oldest.last, o_out_byte, o_last);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_bytes_q.size();
    end

endmodule

[sim/text_stream_line_filter_tb.sv]
// testbench top of the text stream line filter: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module text_stream_line_filter_tb;
    import tslf_pkg::*;

    localparam int unsigned DIGITS       = 6;
    // cycles with no accepted item before the run is declared hung
    localparam int          IDLE_LIMIT   = 5000;
    // settle time once the last expected item is out
    localparam int          DRAIN_CYCLES = 8;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr   = CFG_SQUEEZE_BLANK;
    logic              i_cfg_wdata  = 1'b0;
    logic              push         = 1'b0;
    logic              full;
    logic [7:0]        i_in_byte    = 8'h00;
    logic              i_file_start = 1'b0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [7:0]        o_out_byte;
    logic              o_last;

    int   fail_count;
    int   pending;
    int   burst_left  = 0;
    int   idle_cycles = 0;
    logic pop_on      = 1'b0;
    int   pop_left    = 0;

    always #5 i_clk = ~i_clk;

    text_stream_line_filter #(
        .NUMBER_DIGITS (DIGITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    tslf_expansion_checker #(
        .NUMBER_DIGITS (DIGITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: runs of pops broken by stalls, mostly short, now and then long
    always @(posedge i_clk) begin
        if (pop_left == 0) begin
            pop_on = !pop_on;
            if (pop_on)
                pop_left = $urandom_range(1, 50);
            else if ($urandom_range(0, 3) == 0)
                pop_left = $urandom_range(5, 40);
            else
                pop_left = $urandom_range(1, 3);
        end
        pop_left--;
        pop <= pop_on;
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // one register write; the enable stays up so back-to-back writes keep it steady
    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // all six option registers, written by name
    task automatic set_filter_options(input t_tslf_cfg opt);
        write_reg(CFG_SQUEEZE_BLANK,    opt.squeeze_blank);
        write_reg(CFG_NUMBER_NONBLANK,  opt.number_nonblank);
        write_reg(CFG_NUMBER_ALL,       opt.number_all);
        write_reg(CFG_SHOW_ENDS,        opt.show_ends);
        write_reg(CFG_SHOW_TABS,        opt.show_tabs);
        write_reg(CFG_SHOW_NONPRINTING, opt.show_nonprinting);
        i_cfg_we <= 1'b0;
    endtask

    // sender pause until every expected item is out, then the settle time
    task automatic wait_for_drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // offer one text byte; bursts of random length with random gaps between them
    task automatic send_byte(input logic [7:0] value, input logic first);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push         <= 1'b1;
        i_in_byte    <= value;
        i_file_start <= first;
        do @(posedge i_clk); while (full);
    endtask

    // text-like byte mix: letters, line ends, tabs, control and high bytes, noise
    function automatic logic [7:0] pick_text_byte(input bit line_heavy);
        int         roll;
        logic [7:0] b;
        roll = $urandom_range(0, 99);
        if (line_heavy)
            b = (roll < 85) ? CH_NL : (8'h61 + roll[3:0]);
        else if (roll < 30)
            b = 8'h61 + 8'($urandom_range(0, 25));
        else if (roll < 50)
            b = CH_NL;
        else if (roll < 58)
            b = CH_TAB;
        else if (roll < 70)
            b = 8'($urandom_range(0, 31));
        else if (roll < 76)
            b = 8'($urandom_range(127, 159));
        else if (roll < 88)
            b = 8'($urandom_range(160, 255));
        else
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    initial begin
        t_tslf_cfg  opts;
        logic [5:0] roll6;
        int         n_items;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain pass-through: field extremes and a line end
        set_filter_options('0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CH_NL, 1'b0);

        // every option on: nonblank numbering wins, leading blank lines squeezed,
        // tab shown once, high control, del, plain high bytes untouched
        wait_for_drain();
        set_filter_options('1);
        send_byte(CH_NL, 1'b1);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(CH_NL, 1'b0);

        // number every line, blank ones too, then a file restart on a blank line
        wait_for_drain();
        opts = '0;
        opts.number_all = 1'b1;
        set_filter_options(opts);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b1);

        // random phases: both extremes, a line-heavy run past the hundred mark,
        // then random option mixes; rare file restarts in all but the line-heavy run
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: opts = '1;
                1: opts = '0;
                2: begin
                    opts = '0;
                    opts.number_all = 1'b1;
                    opts.show_ends  = 1'b1;
                end
                default: begin
                    roll6 = 6'($urandom_range(0, 63));
                    opts  = roll6;
                end
            endcase
            wait_for_drain();
            set_filter_options(opts);
            n_items = (p == 2) ? 110 : 25;
            for (int k = 0; k < n_items; k++)
                send_byte(pick_text_byte(p == 2), (p != 2) && ($urandom_range(0, 39) == 0));
        end

        wait_for_drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[text_stream_line_filter.f]
design/tslf_pkg.sv
design/tslf_fifo.sv
design/tslf_front.sv
design/tslf_back.sv
design/text_stream_line_filter.sv
design/tslf_checker.sv
sim/tslf_expansion_checker.sv
sim/text_stream_line_filter_tb.sv
